// ===== design/ghlr_pkg.sv =====
// ----------------------------------------------------------------------------
// ghlr_pkg
// shared types, command codes and default sizes for the hop limited
// reachability engine
// ----------------------------------------------------------------------------
package ghlr_pkg;

   localparam int NODE_COUNT_DEF = 256;
   localparam int EDGE_COUNT_DEF = 256;
   localparam int MAX_DEGREE_DEF = 8;

   localparam logic [2:0] CMD_WR_EDGE    = 3'd0;
   localparam logic [2:0] CMD_WR_SLOT    = 3'd1;
   localparam logic [2:0] CMD_NODE_QUERY = 3'd2;
   localparam logic [2:0] CMD_EDGE_QUERY = 3'd3;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] edge_index;
      logic [7:0] end_a;
      logic [7:0] end_b;
      logic [7:0] node_index;
      logic [2:0] slot;
      logic       slot_valid;
      logic [7:0] source_id;
      logic [7:0] target_id;
      logic [7:0] hop_limit;
      logic       limited;
   } ghlr_req_type;

   typedef struct packed {
      logic capture;
      logic wr_edge;
      logic wr_slot;
      logic clr_run;
      logic clr_all;
      logic seed_node;
      logic rd_src_edge;
      logic seed_a;
      logic seed_b;
      logic fetch;
      logic load_node;
      logic rd_slot;
      logic rd_edge;
      logic rd_vis;
      logic push;
      logic next_slot;
      logic adv_level;
      logic set_found;
   } ghlr_cmd_type;

   typedef struct packed {
      logic src_node_ok;
      logic src_edge_ok;
      logic empty;
      logic over;
      logic slot_last;
      logic slot_vld;
      logic slot_hit;
      logic slot_edge_ok;
      logic far_hit;
      logic far_ok;
      logic found;
      logic clr_last;
   } ghlr_sts_type;

endpackage

// ===== design/graph_hop_limited_reachability.sv =====
// ----------------------------------------------------------------------------
// graph_hop_limited_reachability
// stores an undirected multigraph and answers hop limited reachability
// queries by breadth first search
// ----------------------------------------------------------------------------
// usage:
//  req_ carries one command per transfer, its code in req_tuser: edge write,
//  adjacency slot write, node query or edge query. writes complete in the
//  accept cycle and give no result. each query gives exactly one rsp_
//  transfer with found in bit 0.
//  a query runs one node at a time from a frontier queue; each node takes a
//  frontier check, a queue fetch and a node load, then per adjacency slot a slot
//  read and, when needed, an edge table read and a visited read, one memory
//  port each. when the search ends, a sweep clears the visited marks before
//  req_tready returns. a search stops early on a hit, an empty frontier or a
//  passed hop limit.
//  after reset all NODE_COUNT * MAX_DEGREE adjacency slots are swept clear,
//  one slot per cycle, with req_tready low.
//  the result sits in an output register; while the receiver stalls, one
//  finished result waits there and a further query holds before its result
//  until the register is free.
// ----------------------------------------------------------------------------
module graph_hop_limited_reachability import ghlr_pkg::*; #(
   parameter int NODE_COUNT = NODE_COUNT_DEF,
   parameter int EDGE_COUNT = EDGE_COUNT_DEF,
   parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // edge_index, end_a, end_b, node_index, slot, slot_valid,
   // source_id, target_id, hop_limit, limited, zero fill
   input  logic [63:0] req_tdata,
   // command
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // found, zero fill
   output logic [7:0]  rsp_tdata
);

   ghlr_req_type req;
   ghlr_cmd_type cmd;
   ghlr_sts_type sts;
   logic         rsp_found;

   assign req.command    = req_tuser;
   assign req.edge_index = req_tdata[7:0];
   assign req.end_a      = req_tdata[15:8];
   assign req.end_b      = req_tdata[23:16];
   assign req.node_index = req_tdata[31:24];
   assign req.slot       = req_tdata[34:32];
   assign req.slot_valid = req_tdata[35];
   assign req.source_id  = req_tdata[43:36];
   assign req.target_id  = req_tdata[51:44];
   assign req.hop_limit  = req_tdata[59:52];
   assign req.limited    = req_tdata[60];

   assign rsp_tdata = {7'd0, rsp_found};

   ghlr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_command (req.command),
      .req_tready  (req_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_found   (rsp_found),
      .rsp_tready  (rsp_tready),
      .sts         (sts),
      .cmd         (cmd)
   );

   ghlr_dp #(
      .NODE_COUNT (NODE_COUNT),
      .EDGE_COUNT (EDGE_COUNT),
      .MAX_DEGREE (MAX_DEGREE)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .cmd   (cmd),
      .sts   (sts)
   );

endmodule

// ===== design/ghlr_dp.sv =====
// ----------------------------------------------------------------------------
// ghlr_dp
// datapath: edge table, adjacency store, visited marks, frontier queue,
// pointers and compares
// ----------------------------------------------------------------------------
module ghlr_dp import ghlr_pkg::*; #(
   parameter int NODE_COUNT = NODE_COUNT_DEF,
   parameter int EDGE_COUNT = EDGE_COUNT_DEF,
   parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  ghlr_req_type req,
   input  ghlr_cmd_type cmd,
   output ghlr_sts_type sts
);

   localparam int ADJ_DEPTH = NODE_COUNT * MAX_DEGREE;
   localparam int NW = $clog2(NODE_COUNT);
   localparam int EW = (EDGE_COUNT > 1) ? $clog2(EDGE_COUNT) : 1;
   localparam int SW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
   localparam int AW = $clog2(ADJ_DEPTH);
   localparam int PW = NW + 1;
   localparam int LW = $clog2(NODE_COUNT + 2);
   localparam int CW = $clog2(ADJ_DEPTH + 1);

   logic [15:0]   edge_mem  [EDGE_COUNT];
   logic [8:0]    adj_mem   [ADJ_DEPTH];
   logic          vis_mem   [NODE_COUNT];
   logic [NW-1:0] queue_mem [NODE_COUNT];

   logic [7:0]    source_ff, target_ff, hop_ff, other_ff;
   logic          limited_ff, edge_mode_ff, found_ff;
   logic [PW-1:0] head_ff, tail_ff, level_end_ff;
   logic [LW-1:0] level_ff;
   logic [NW-1:0] node_ff, q_rd_ff;
   logic [SW-1:0] slot_ff;
   logic [15:0]   edge_rd_ff;
   logic [8:0]    adj_rd_ff;
   logic          vis_rd_ff;
   logic [CW-1:0] clr_ff;

   logic [7:0]    end_a, end_b, other_in, mark_id;
   logic          a_ok, b_ok, mark_en;
   logic          wr_edge_ok, wr_slot_ok, clr_vis_ok;
   logic [AW-1:0] adj_rd_addr, adj_wr_addr;
   logic [EW-1:0] edge_rd_addr;
   logic [NW-1:0] q_wr_addr;

   assign end_a    = edge_rd_ff[7:0];
   assign end_b    = edge_rd_ff[15:8];
   assign a_ok     = 32'(end_a) < NODE_COUNT;
   assign b_ok     = 32'(end_b) < NODE_COUNT;
   assign other_in = (32'(node_ff) != 32'(end_a)) ? end_a : end_b;

   assign wr_edge_ok = cmd.wr_edge && (32'(req.edge_index) < EDGE_COUNT);
   assign wr_slot_ok = cmd.wr_slot && (32'(req.node_index) < NODE_COUNT)
                       && (32'(req.slot) < MAX_DEGREE)
                       && (!req.slot_valid || (32'(req.edge_index) < EDGE_COUNT));
   assign clr_vis_ok = 32'(clr_ff) < NODE_COUNT;

   assign adj_rd_addr  = AW'(32'(node_ff) * MAX_DEGREE + 32'(slot_ff));
   assign adj_wr_addr  = AW'(32'(req.node_index) * MAX_DEGREE + 32'(req.slot));
   assign edge_rd_addr = cmd.rd_src_edge ? EW'(source_ff) : EW'(adj_rd_ff[7:0]);

   // first seed of a query goes to the queue head
   assign q_wr_addr = (cmd.seed_node || cmd.seed_a) ? '0 : tail_ff[NW-1:0];

   always_comb begin
      mark_en = 1'b0;
      mark_id = source_ff;
      if (cmd.seed_node) begin
         mark_en = 1'b1;
      end else if (cmd.seed_a) begin
         mark_en = a_ok;
         mark_id = end_a;
      end else if (cmd.seed_b) begin
         mark_en = b_ok && !(a_ok && (end_a == end_b));
         mark_id = end_b;
      end else if (cmd.push) begin
         mark_en = !vis_rd_ff;
         mark_id = other_ff;
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (wr_edge_ok) begin
         edge_mem[EW'(req.edge_index)] <= {req.end_b, req.end_a};
      end
      if (cmd.rd_edge || cmd.rd_src_edge) begin
         edge_rd_ff <= edge_mem[edge_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_run && cmd.clr_all) begin
         adj_mem[clr_ff[AW-1:0]] <= 9'd0;
      end else if (wr_slot_ok) begin
         adj_mem[adj_wr_addr] <= req.slot_valid ? {1'b1, req.edge_index} : 9'd0;
      end
      if (cmd.rd_slot) begin
         adj_rd_ff <= adj_mem[adj_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_run && clr_vis_ok) begin
         vis_mem[clr_ff[NW-1:0]] <= 1'b0;
      end else if (mark_en) begin
         vis_mem[NW'(mark_id)] <= 1'b1;
      end
      if (cmd.rd_vis) begin
         vis_rd_ff <= vis_mem[NW'(other_in)];
      end
   end

   always_ff @(posedge clock) begin
      if (mark_en) begin
         queue_mem[q_wr_addr] <= NW'(mark_id);
      end
      if (cmd.fetch) begin
         q_rd_ff <= queue_mem[head_ff[NW-1:0]];
      end
   end

   // query payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         source_ff    <= req.source_id;
         target_ff    <= req.target_id;
         hop_ff       <= req.hop_limit;
         limited_ff   <= req.limited;
         edge_mode_ff <= (req.command == CMD_EDGE_QUERY);
      end
      if (cmd.load_node) begin
         node_ff <= q_rd_ff;
         slot_ff <= '0;
      end else if (cmd.next_slot) begin
         slot_ff <= slot_ff + SW'(1);
      end
      if (cmd.rd_vis) begin
         other_ff <= other_in;
      end
   end

   // pointers and flags
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         level_end_ff <= '0;
         level_ff     <= '0;
         clr_ff       <= '0;
         found_ff     <= 1'b0;
      end else begin
         clr_ff <= cmd.clr_run ? clr_ff + CW'(1) : '0;
         if (cmd.capture) begin
            found_ff <= 1'b0;
         end else if (cmd.set_found) begin
            found_ff <= 1'b1;
         end
         if (cmd.seed_node || cmd.seed_a) begin
            head_ff      <= '0;
            level_ff     <= '0;
            tail_ff      <= mark_en ? PW'(1) : '0;
            level_end_ff <= mark_en ? PW'(1) : '0;
         end else if (cmd.seed_b) begin
            tail_ff      <= tail_ff + PW'(mark_en);
            level_end_ff <= tail_ff + PW'(mark_en);
         end else begin
            if (mark_en) begin
               tail_ff <= tail_ff + PW'(1);
            end
            if (cmd.fetch) begin
               head_ff <= head_ff + PW'(1);
            end
            if (cmd.adv_level && (head_ff == level_end_ff)) begin
               level_end_ff <= tail_ff;
               level_ff     <= level_ff + LW'(1);
            end
         end
      end
   end

   always_comb begin
      sts.src_node_ok  = 32'(source_ff) < NODE_COUNT;
      sts.src_edge_ok  = 32'(source_ff) < EDGE_COUNT;
      sts.empty        = head_ff == tail_ff;
      sts.over         = limited_ff && (32'(level_ff) > 32'(hop_ff));
      sts.slot_last    = 32'(slot_ff) == MAX_DEGREE - 1;
      sts.slot_vld     = adj_rd_ff[8];
      sts.slot_hit     = edge_mode_ff && (adj_rd_ff[7:0] == target_ff);
      sts.slot_edge_ok = 32'(adj_rd_ff[7:0]) < EDGE_COUNT;
      sts.far_hit      = !edge_mode_ff && (other_in == target_ff);
      sts.far_ok       = 32'(other_in) < NODE_COUNT;
      sts.found        = found_ff;
      sts.clr_last     = cmd.clr_all ? (32'(clr_ff) == ADJ_DEPTH - 1)
                                     : (32'(clr_ff) == NODE_COUNT - 1);
   end

   a_head_le_tail: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff) else $error("queue head passed tail");
   a_tail_bound: assert property (@(posedge clock) disable iff (reset)
      32'(tail_ff) <= NODE_COUNT) else $error("queue overflow");
   a_level_end: assert property (@(posedge clock) disable iff (reset)
      cmd.fetch |-> head_ff < level_end_ff) else $error("fetch beyond level");

endmodule

// ===== design/ghlr_ctrl.sv =====
// ----------------------------------------------------------------------------
// ghlr_ctrl
// sequencer for commands, breadth first search steps, result register and
// clearing sweeps
// ----------------------------------------------------------------------------
module ghlr_ctrl import ghlr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic [2:0]   req_command,
   output logic         req_tready,
   output logic         rsp_tvalid,
   output logic         rsp_found,
   input  logic         rsp_tready,
   input  ghlr_sts_type sts,
   output ghlr_cmd_type cmd
);

   typedef enum logic [3:0] {
      S_CLEAR_ALL, S_IDLE, S_SEED_NODE, S_EDGE_RD, S_SEED_A, S_SEED_B,
      S_CHECK, S_FETCH, S_NODE, S_SLOT_RD, S_SLOT_CHK, S_FAR_CHK,
      S_VIS_CHK, S_LEVEL, S_DONE, S_CLEAR_VIS
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff, rsp_found_ff;
   logic      accept, rsp_free;

   assign accept     = req_tvalid && (state_ff == S_IDLE);
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR_ALL: begin
            cmd.clr_run = 1'b1;
            cmd.clr_all = 1'b1;
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            cmd.capture = accept;
            cmd.wr_edge = accept && (req_command == CMD_WR_EDGE);
            cmd.wr_slot = accept && (req_command == CMD_WR_SLOT);
            if (accept && (req_command == CMD_NODE_QUERY)) state_in = S_SEED_NODE;
            if (accept && (req_command == CMD_EDGE_QUERY)) state_in = S_EDGE_RD;
         end
         S_SEED_NODE: begin
            cmd.seed_node = sts.src_node_ok;
            state_in = sts.src_node_ok ? S_CHECK : S_DONE;
         end
         S_EDGE_RD: begin
            cmd.rd_src_edge = sts.src_edge_ok;
            state_in = sts.src_edge_ok ? S_SEED_A : S_DONE;
         end
         S_SEED_A: begin
            cmd.seed_a = 1'b1;
            state_in   = S_SEED_B;
         end
         S_SEED_B: begin
            cmd.seed_b = 1'b1;
            state_in   = S_CHECK;
         end
         S_CHECK: begin
            state_in = (sts.empty || sts.over) ? S_DONE : S_FETCH;
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_NODE;
         end
         S_NODE: begin
            cmd.load_node = 1'b1;
            state_in      = S_SLOT_RD;
         end
         S_SLOT_RD: begin
            cmd.rd_slot = 1'b1;
            state_in    = S_SLOT_CHK;
         end
         S_SLOT_CHK: begin
            if (sts.slot_vld && sts.slot_hit) begin
               cmd.set_found = 1'b1;
               state_in      = S_DONE;
            end else if (sts.slot_vld && sts.slot_edge_ok) begin
               cmd.rd_edge = 1'b1;
               state_in    = S_FAR_CHK;
            end else begin
               cmd.next_slot = !sts.slot_last;
               state_in      = sts.slot_last ? S_LEVEL : S_SLOT_RD;
            end
         end
         S_FAR_CHK: begin
            if (sts.far_hit) begin
               cmd.set_found = 1'b1;
               state_in      = S_DONE;
            end else if (sts.far_ok) begin
               cmd.rd_vis = 1'b1;
               state_in   = S_VIS_CHK;
            end else begin
               cmd.next_slot = !sts.slot_last;
               state_in      = sts.slot_last ? S_LEVEL : S_SLOT_RD;
            end
         end
         S_VIS_CHK: begin
            cmd.push      = 1'b1;
            cmd.next_slot = !sts.slot_last;
            state_in      = sts.slot_last ? S_LEVEL : S_SLOT_RD;
         end
         S_LEVEL: begin
            cmd.adv_level = 1'b1;
            state_in      = S_CHECK;
         end
         S_DONE: begin
            if (rsp_free) state_in = S_CLEAR_VIS;
         end
         S_CLEAR_VIS: begin
            cmd.clr_run = 1'b1;
            if (sts.clr_last) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR_ALL;
         rsp_tvalid_ff <= 1'b0;
         rsp_found_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if ((state_ff == S_DONE) && rsp_free) begin
            rsp_tvalid_ff <= 1'b1;
            rsp_found_ff  <= sts.found;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == S_DONE))
      else $error("result without finished query");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !cmd.capture) else $error("accept while busy");
   a_found_only_search: assert property (@(posedge clock) disable iff (reset)
      cmd.set_found |=> (state_ff == S_DONE)) else $error("hit not finishing query");

endmodule

// ===== sim/tb_graph_hop_limited_reachability.sv =====
// ----------------------------------------------------------------------------
// tb_graph_hop_limited_reachability
// builds small multigraphs through edge and adjacency slot writes, runs node
// and edge reachability queries with and without a hop limit, and checks
// found flag against a breadth first search kept in the testbench, or against a
// given expected value for the directed rows marked known
`timescale 1ns / 1ps

module tb_graph_hop_limited_reachability;
   import ghlr_pkg::*;

   localparam int RANDOM_ITEMS = 115;
   localparam int QUIET_ITEMS  = 30;
   localparam int CYCLE_LIMIT  = 10000000;

   // item bits: command, then the tdata fields from the lowest bit up
   typedef struct {
      logic [66:0] data;
      bit          known;
      bit          exp_found;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [7:0]  rsp_tdata;

   logic [15:0] edge_mem [256];
   logic [8:0]  slot_mem [2048];
   bit          edge_written [256];
   int          written_edges [$];
   bit          expected_found_q [$];
   dir_row_type dir_rows [$];
   int          errors = 0;
   int          cycles = 0;
   bit          quiet = 1'b0;

   graph_hop_limited_reachability u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      errors++;
      $display("mismatch: %s", msg);
   endtask

   function automatic logic [66:0] pack_req(logic [2:0] cmd, logic [7:0] ei, logic [7:0] ea,
                                            logic [7:0] eb, logic [7:0] ni, logic [2:0] sl,
                                            logic sv, logic [7:0] src, logic [7:0] tgt,
                                            logic [7:0] hop, logic lim);
      return {3'd0, lim, hop, tgt, src, sv, sl, ni, eb, ea, ei, cmd};
   endfunction

   task automatic add_row(input logic [66:0] d, input bit known, input bit exp_found);
      dir_row_type row;
      row.data      = d;
      row.known     = known;
      row.exp_found = exp_found;
      dir_rows.insert(dir_rows.size(), row);
   endtask

   function automatic int far_node(int e, int here);
      int a;
      int b;
      a = int'(edge_mem[e][7:0]);
      b = int'(edge_mem[e][15:8]);
      return (here != a) ? a : b;
   endfunction

   // level by level search from the start nodes
   function automatic bit reach_bfs(int starts [$], bit edge_mode, int target, bit lim, int hop);
      int  cur [$];
      int  nxt [$];
      bit  mark [256];
      int  level;
      bit  hit;
      int  node;
      int  e;
      int  other;
      logic [8:0] s;
      level = 0;
      hit = 1'b0;
      foreach (starts[i]) begin
         if (!mark[starts[i]]) begin
            mark[starts[i]] = 1'b1;
            cur.insert(cur.size(), starts[i]);
         end
      end
      while (!hit && cur.size() > 0 && (!lim || level <= hop)) begin
         nxt.delete();
         for (int i = 0; i < cur.size() && !hit; i++) begin
            node = cur[i];
            for (int k = 0; k < 8; k++) begin
               s = slot_mem[node * 8 + k];
               if (!s[8]) continue;
               e = int'(s[7:0]);
               if (edge_mode && e == target) begin
                  hit = 1'b1;
                  break;
               end
               other = far_node(e, node);
               if (!edge_mode && other == target) begin
                  hit = 1'b1;
                  break;
               end
               if (!mark[other]) begin
                  mark[other] = 1'b1;
                  nxt.insert(nxt.size(), other);
               end
            end
         end
         cur = nxt;
         level++;
      end
      return hit;
   endfunction

   // updates the graph copy; returns 1 when the command gives a result
   function automatic bit predict_reach(logic [66:0] d, output bit found);
      logic [2:0] cmd;
      int         starts [$];
      cmd = d[2:0];
      found = 1'b0;
      case (cmd)
         CMD_WR_EDGE: begin
            edge_mem[d[10:3]] = {d[26:19], d[18:11]};
            return 1'b0;
         end
         CMD_WR_SLOT: begin
            slot_mem[{d[34:27], d[37:35]}] = d[38] ? {1'b1, d[10:3]} : 9'd0;
            return 1'b0;
         end
         CMD_NODE_QUERY: begin
            starts.insert(starts.size(), int'(d[46:39]));
            found = reach_bfs(starts, 1'b0, int'(d[54:47]), d[63], int'(d[62:55]));
            return 1'b1;
         end
         CMD_EDGE_QUERY: begin
            starts.insert(starts.size(), int'(edge_mem[d[46:39]][7:0]));
            starts.insert(starts.size(), int'(edge_mem[d[46:39]][15:8]));
            found = reach_bfs(starts, 1'b1, int'(d[54:47]), d[63], int'(d[62:55]));
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   task automatic send_req(input logic [66:0] d, input bit known, input bit exp_found);
      bit f;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= d[2:0];
      req_tdata  <= d[66:3];
      do @(posedge clock); while (!req_tready);
      if (predict_reach(d, f))
         expected_found_q.insert(expected_found_q.size(), known ? exp_found : f);
      @(negedge clock);
   endtask

   function automatic logic [7:0] pick_node();
      return ($urandom_range(0, 6) != 0) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] pick_written();
      return 8'(written_edges[$urandom_range(0, written_edges.size() - 1)]);
   endfunction

   function automatic logic [66:0] gen_item();
      logic [2:0] cmd;
      logic [7:0] ei, ea, eb, ni, src, tgt, hop;
      logic [2:0] sl;
      logic       sv, lim;
      int         r;
      r = $urandom_range(0, 99);
      cmd = CMD_NODE_QUERY;
      ei = 8'($urandom); ea = 8'($urandom); eb = 8'($urandom); ni = 8'($urandom);
      sl = 3'($urandom); sv = 1'($urandom); src = 8'($urandom); tgt = 8'($urandom);
      lim = 1'($urandom);
      hop = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
      if (r < 25) begin
         cmd = CMD_WR_EDGE;
         ei = pick_node(); ea = pick_node(); eb = pick_node();
         if (!edge_written[ei]) begin
            edge_written[ei] = 1'b1;
            written_edges.insert(written_edges.size(), int'(ei));
         end
      end else if (r < 60) begin
         cmd = CMD_WR_SLOT;
         ni = pick_node();
         sv = ($urandom_range(0, 6) != 0);
         if (sv) ei = pick_written();
      end else if (r < 80) begin
         cmd = CMD_NODE_QUERY;
         src = pick_node(); tgt = pick_node();
      end else if (r < 95) begin
         cmd = CMD_EDGE_QUERY;
         src = pick_written();
         tgt = ($urandom_range(0, 4) != 0) ? pick_written() : 8'($urandom);
      end else begin
         cmd = 3'($urandom_range(4, 7));
      end
      return pack_req(cmd, ei, ea, eb, ni, sl, sv, src, tgt, hop, lim);
   endfunction

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[graph_hop_limited_reachability] ERROR");
         $finish;
      end
      if (rsp_tvalid && rsp_tready) begin
         if (expected_found_q.size() == 0)
            report_mismatch($sformatf("unexpected result %h", rsp_tdata));
         else if (rsp_tdata !== {7'd0, expected_found_q[0]}) begin
            report_mismatch($sformatf("found %h, want %0d", rsp_tdata, expected_found_q[0]));
            void'(expected_found_q.pop_front());
         end else
            void'(expected_found_q.pop_front());
      end
   end

   // receiver stalls
   initial begin
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      foreach (edge_written[i]) edge_written[i] = 1'b0;
      foreach (slot_mem[i]) slot_mem[i] = 9'd0;
      foreach (edge_mem[i]) edge_mem[i] = 16'd0;
      // empty graph, self loop, extremes, foreign slot, invalid slot, unused command
      add_row(pack_req(CMD_NODE_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0);
      add_row(pack_req(CMD_NODE_QUERY, 0, 0, 0, 0, 0, 0, 255, 255, 255, 1), 1, 0);
      add_row(pack_req(CMD_WR_EDGE, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0), 0, 0);
      add_row(pack_req(CMD_WR_EDGE, 1, 1, 2, 0, 0, 0, 0, 0, 0, 0), 0, 0);
      add_row(pack_req(CMD_WR_EDGE, 2, 2, 2, 0, 0, 0, 0, 0, 0, 0), 0, 0);
      add_row(pack_req(CMD_WR_EDGE, 3, 7, 200, 0, 0, 0, 0, 0, 0, 0), 0, 0);
      add_row(pack_req(CMD_WR_EDGE, 255, 254, 255, 0, 0, 0, 0, 0, 0, 0), 0, 0);
      add_row(pack_req(CMD_WR_SLOT, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0), 0, 0);
      add_row(pack_req(CMD_WR_SLOT, 0, 0, 0, 1, 0, 1, 0, 0, 0, 0), 0, 0);
      add_row(pack_req(CMD_WR_SLOT, 1, 0, 0, 1, 7, 1, 0, 0, 0, 0), 0, 0);
      add_row(pack_req(CMD_WR_SLOT, 2, 0, 0, 2, 3, 1, 0, 0, 0, 0), 0, 0);
      add_row(pack_req(CMD_WR_SLOT, 1, 0, 0, 5, 0, 1, 0, 0, 0, 0), 0, 0);
      add_row(pack_req(CMD_WR_SLOT, 255, 0, 0, 255, 7, 1, 0, 0, 0, 0), 0, 0);
      add_row(pack_req(CMD_WR_SLOT, 255, 0, 0, 254, 0, 1, 0, 0, 0, 0), 0, 0);
      add_row(pack_req(3'd7, 255, 255, 255, 255, 7, 1, 255, 255, 255, 1), 0, 0);
      add_row(pack_req(CMD_NODE_QUERY, 0, 0, 0, 0, 0, 0, 0, 2, 0, 1), 0, 0);
      add_row(pack_req(CMD_NODE_QUERY, 0, 0, 0, 0, 0, 0, 0, 2, 1, 1), 0, 0);
      add_row(pack_req(CMD_NODE_QUERY, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0), 0, 0);
      add_row(pack_req(CMD_NODE_QUERY, 0, 0, 0, 0, 0, 0, 5, 2, 0, 0), 0, 0);
      add_row(pack_req(CMD_NODE_QUERY, 0, 0, 0, 0, 0, 0, 254, 255, 255, 1), 0, 0);
      add_row(pack_req(CMD_EDGE_QUERY, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1), 0, 0);
      add_row(pack_req(CMD_EDGE_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0);
      add_row(pack_req(CMD_EDGE_QUERY, 0, 0, 0, 0, 0, 0, 255, 255, 0, 1), 0, 0);
      add_row(pack_req(CMD_WR_SLOT, 1, 0, 0, 1, 7, 0, 0, 0, 0, 0), 0, 0);
      add_row(pack_req(CMD_EDGE_QUERY, 0, 0, 0, 0, 0, 0, 1, 2, 0, 0), 0, 0);
      foreach (dir_rows[i]) begin
         if (dir_rows[i].data[2:0] == CMD_WR_EDGE && !edge_written[dir_rows[i].data[10:3]]) begin
            edge_written[dir_rows[i].data[10:3]] = 1'b1;
            written_edges.insert(written_edges.size(), int'(dir_rows[i].data[10:3]));
         end
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send_req(dir_rows[i].data, dir_rows[i].known, dir_rows[i].exp_found);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
         send_req(gen_item(), 1'b0, 1'b0);
      end
      req_tvalid <= 1'b0;

      while (expected_found_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0)
         $display("[graph_hop_limited_reachability] OK");
      else
         $display("[graph_hop_limited_reachability] ERROR");
      $finish;
   end

endmodule
